>>> sv/cau_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_pkg
// Operation and status codes shared by the complex arithmetic unit and its
// port checker.
// ----------------------------------------------------------------------------
package cau_pkg;

    typedef logic [2:0] act_t;
    typedef logic [1:0] status_t;

    localparam act_t ACT_ADD  = 3'd0;
    localparam act_t ACT_SUB  = 3'd1;
    localparam act_t ACT_MUL  = 3'd2;
    localparam act_t ACT_DIV  = 3'd3;
    localparam act_t ACT_CONJ = 3'd4;
    localparam act_t ACT_MAG  = 3'd5;

    localparam status_t STAT_OK   = 2'd0;
    localparam status_t STAT_DIVZ = 2'd1;
    localparam status_t STAT_SAT  = 2'd2;

endpackage
`default_nettype wire

>>> sv/complex_arithmetic_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex ALU on signed fixed point: add, subtract, multiply,
// divide, conjugate and magnitude, with saturation and divide-by-zero status.
// ----------------------------------------------------------------------------
//  Channel | Handshake            | Payload
//  --------+----------------------+------------------------------------------
//  input   | in_valid / in_ready  | action, a_re, a_im, b_re, b_im
//  output  | out_valid / out_ready| res_re, res_im, status
//
// One transaction enters per cycle while the output is not stalled. The pipeline has
// 48 quotient step stages plus five other stages at the default Q16.16; its length
// is set by the divider, which retires one quotient bit per stage; the square root
// runs alongside it, one result bit per stage in the first DATA_WIDTH step stages.
// Reset clears only the valid bits. When the output holds a result that is
// not taken, the whole pipeline freezes and in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    output logic                         in_ready,
    input  wire cau_pkg::act_t           action,
    input  wire signed [DATA_WIDTH-1:0]  a_re,
    input  wire signed [DATA_WIDTH-1:0]  a_im,
    input  wire signed [DATA_WIDTH-1:0]  b_re,
    input  wire signed [DATA_WIDTH-1:0]  b_im,
    output logic                         out_valid,
    input  wire                          out_ready,
    output logic signed [DATA_WIDTH-1:0] res_re,
    output logic signed [DATA_WIDTH-1:0] res_im,
    output cau_pkg::status_t             status
);
    import cau_pkg::*;

    localparam int DW    = DATA_WIDTH;
    localparam int FB    = FRAC_BITS;
    localparam int PW    = 2 * DW;
    localparam int QW    = DW + FB;
    localparam int STEPS = QW;
    localparam int CW    = (PW + 1 > QW + 1) ? PW + 1 : QW + 1;
    localparam logic [PW:0] HALF = ({{PW{1'b0}}, 1'b1} << FB) >> 1;
    localparam logic [CW-1:0] LIM = {{(CW-1){1'b0}}, 1'b1} << (DW - 1);

    // Clamp a signed sum that has one guard bit.
    function automatic logic [DW:0] clamp_sum(input logic [DW:0] s);
        logic sat;
        sat = s[DW] ^ s[DW-1];
        return sat ? {1'b1, s[DW], {(DW-1){~s[DW]}}} : {1'b0, s[DW-1:0]};
    endfunction

    // Clamp a sign/magnitude value; the top bit of the result is the flag.
    function automatic logic [DW:0] clamp_sm(input logic neg, input logic [CW-1:0] mag);
        logic [CW-1:0] m;
        logic          sat;
        m   = mag;
        sat = 1'b0;
        if (neg) begin
            if (mag > LIM) begin
                sat = 1'b1;
                m   = LIM;
            end
            return {sat, DW'(~m + 1'b1)};
        end
        if (mag > LIM - 1'b1) begin
            sat = 1'b1;
            m   = LIM - 1'b1;
        end
        return {sat, m[DW-1:0]};
    endfunction

    logic en;

    // Stage 1: input register.
    logic                 s1_valid_reg;
    act_t                 s1_act_reg;
    logic signed [DW-1:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    // Stage 2: products and the simple results.
    logic                 s2_valid_reg;
    act_t                 s2_act_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [PW-1:0] p4_next, p5_next;
    logic [DW:0]          e2_re_next, e2_im_next;
    logic [DW-1:0]        e2_re_reg, e2_im_reg;
    logic                 e2_sat_reg;

    // Stage 3: sums in sign/magnitude form.
    logic                 s3_valid_reg;
    act_t                 s3_act_reg;
    logic signed [PW:0]   sum_re_next, sum_im_next;
    logic                 neg_re_reg, neg_im_reg;
    logic [PW-1:0]        mag_re_reg, mag_im_reg, d_reg;
    logic [DW-1:0]        e3_re_reg, e3_im_reg;
    logic                 e3_sat_reg;

    // Step stages: index 0 is the set-up stage, index j+1 follows step j.
    logic          st_valid_reg [0:STEPS];
    act_t          st_act_reg   [0:STEPS];
    logic [DW-1:0] st_ere_reg   [0:STEPS];
    logic [DW-1:0] st_eim_reg   [0:STEPS];
    logic          st_esat_reg  [0:STEPS];
    logic          st_dz_reg    [0:STEPS];
    logic          st_nre_reg   [0:STEPS];
    logic          st_nim_reg   [0:STEPS];
    logic          st_sre_reg   [0:STEPS];
    logic          st_sim_reg   [0:STEPS];
    logic [PW-1:0] st_rre_reg   [0:STEPS];
    logic [PW-1:0] st_rim_reg   [0:STEPS];
    logic [QW-1:0] st_qre_reg   [0:STEPS];
    logic [QW-1:0] st_qim_reg   [0:STEPS];
    logic [PW-1:0] st_d_reg     [0:STEPS];
    logic [PW-1:0] st_op_reg    [0:STEPS];
    logic [PW-1:0] st_res_reg   [0:STEPS];

    logic [PW-1:0] rre_next [0:STEPS-1];
    logic [PW-1:0] rim_next [0:STEPS-1];
    logic [QW-1:0] qre_next [0:STEPS-1];
    logic [QW-1:0] qim_next [0:STEPS-1];
    logic [PW-1:0] op_next  [0:STEPS-1];
    logic [PW-1:0] res_next [0:STEPS-1];

    // Set-up stage inputs.
    logic [PW:0]   rnd_re, rnd_im;
    logic [DW:0]   mul_re, mul_im;
    logic [DW-1:0] ere0_next, eim0_next;
    logic          esat0_next;

    // Output register.
    logic          out_valid_reg;
    logic [DW-1:0] out_re_reg, out_im_reg, out_re_next, out_im_next;
    status_t       out_stat_reg, out_stat_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j <= STEPS; j++) begin
                st_valid_reg[j] <= 1'b0;
            end
        end else if (en) begin
            s1_valid_reg    <= in_valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            st_valid_reg[0] <= s3_valid_reg;
            for (int j = 0; j < STEPS; j++) begin
                st_valid_reg[j+1] <= st_valid_reg[j];
            end
            out_valid_reg <= st_valid_reg[STEPS];
        end
    end

    // Stage 1 capture.
    always_ff @(posedge clk)
    begin
        if (en) begin
            s1_act_reg <= action;
            s1_ar_reg  <= a_re;
            s1_ai_reg  <= a_im;
            s1_br_reg  <= b_re;
            s1_bi_reg  <= b_im;
        end
    end

    // Stage 2: the squares serve the divisor norm or the magnitude.
    always_comb
    begin
        if (s1_act_reg == ACT_MAG) begin
            p4_next = s1_ar_reg * s1_ar_reg;
            p5_next = s1_ai_reg * s1_ai_reg;
        end else begin
            p4_next = s1_br_reg * s1_br_reg;
            p5_next = s1_bi_reg * s1_bi_reg;
        end
        e2_re_next = '0;
        e2_im_next = '0;
        case (s1_act_reg)
            ACT_ADD: begin
                e2_re_next = clamp_sum({s1_ar_reg[DW-1], s1_ar_reg} + {s1_br_reg[DW-1], s1_br_reg});
                e2_im_next = clamp_sum({s1_ai_reg[DW-1], s1_ai_reg} + {s1_bi_reg[DW-1], s1_bi_reg});
            end
            ACT_SUB: begin
                e2_re_next = clamp_sum({s1_ar_reg[DW-1], s1_ar_reg} - {s1_br_reg[DW-1], s1_br_reg});
                e2_im_next = clamp_sum({s1_ai_reg[DW-1], s1_ai_reg} - {s1_bi_reg[DW-1], s1_bi_reg});
            end
            ACT_CONJ: begin
                e2_re_next = {1'b0, s1_ar_reg};
                e2_im_next = clamp_sum((DW+1)'(0) - {s1_ai_reg[DW-1], s1_ai_reg});
            end
            default: begin
                e2_re_next = '0;
                e2_im_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s2_act_reg <= s1_act_reg;
            p0_reg     <= s1_ar_reg * s1_br_reg;
            p1_reg     <= s1_ai_reg * s1_bi_reg;
            p2_reg     <= s1_ar_reg * s1_bi_reg;
            p3_reg     <= s1_ai_reg * s1_br_reg;
            p4_reg     <= p4_next;
            p5_reg     <= p5_next;
            e2_re_reg  <= e2_re_next[DW-1:0];
            e2_im_reg  <= e2_im_next[DW-1:0];
            e2_sat_reg <= e2_re_next[DW] | e2_im_next[DW];
        end
    end

    // Stage 3: exact dot products; multiply and divide differ in signs.
    always_comb
    begin
        if (s2_act_reg == ACT_DIV) begin
            sum_re_next = (PW+1)'(p0_reg) + (PW+1)'(p1_reg);
            sum_im_next = (PW+1)'(p3_reg) - (PW+1)'(p2_reg);
        end else begin
            sum_re_next = (PW+1)'(p0_reg) - (PW+1)'(p1_reg);
            sum_im_next = (PW+1)'(p2_reg) + (PW+1)'(p3_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            s3_act_reg <= s2_act_reg;
            neg_re_reg <= sum_re_next[PW];
            neg_im_reg <= sum_im_next[PW];
            mag_re_reg <= sum_re_next[PW] ? PW'(-sum_re_next) : PW'(sum_re_next);
            mag_im_reg <= sum_im_next[PW] ? PW'(-sum_im_next) : PW'(sum_im_next);
            d_reg      <= PW'(p4_reg) + PW'(p5_reg);
            e3_re_reg  <= e2_re_reg;
            e3_im_reg  <= e2_im_reg;
            e3_sat_reg <= e2_sat_reg;
        end
    end

    // Set-up stage: rounding of the product, divider and root seeds.
    always_comb
    begin
        rnd_re = ({1'b0, mag_re_reg} + HALF) >> FB;
        rnd_im = ({1'b0, mag_im_reg} + HALF) >> FB;
        mul_re = clamp_sm(neg_re_reg, CW'(rnd_re));
        mul_im = clamp_sm(neg_im_reg, CW'(rnd_im));
        if (s3_act_reg == ACT_MUL) begin
            ere0_next  = mul_re[DW-1:0];
            eim0_next  = mul_im[DW-1:0];
            esat0_next = mul_re[DW] | mul_im[DW];
        end else begin
            ere0_next  = e3_re_reg;
            eim0_next  = e3_im_reg;
            esat0_next = e3_sat_reg;
        end
    end

    // One restoring divide step per stage for both parts, plus one root bit in each of the first DW stages.
    always_comb
    begin
        for (int j = 0; j < STEPS; j++) begin
            logic [PW-1:0] t_re, t_im, bit_v;
            logic [PW:0]   trial;
            t_re = {st_rre_reg[j][PW-2:0], st_qre_reg[j][QW-1]};
            t_im = {st_rim_reg[j][PW-2:0], st_qim_reg[j][QW-1]};
            if (t_re >= st_d_reg[j]) begin
                rre_next[j] = t_re - st_d_reg[j];
                qre_next[j] = {st_qre_reg[j][QW-2:0], 1'b1};
            end else begin
                rre_next[j] = t_re;
                qre_next[j] = {st_qre_reg[j][QW-2:0], 1'b0};
            end
            if (t_im >= st_d_reg[j]) begin
                rim_next[j] = t_im - st_d_reg[j];
                qim_next[j] = {st_qim_reg[j][QW-2:0], 1'b1};
            end else begin
                rim_next[j] = t_im;
                qim_next[j] = {st_qim_reg[j][QW-2:0], 1'b0};
            end
            op_next[j]  = st_op_reg[j];
            res_next[j] = st_res_reg[j];
            if (j < DW) begin
                bit_v = {{(PW-1){1'b0}}, 1'b1} << (2 * (DW - 1 - j));
                trial = {1'b0, st_res_reg[j]} + {1'b0, bit_v};
                if ({1'b0, st_op_reg[j]} >= trial) begin
                    op_next[j]  = st_op_reg[j] - trial[PW-1:0];
                    res_next[j] = (st_res_reg[j] >> 1) + bit_v;
                end else begin
                    res_next[j] = st_res_reg[j] >> 1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            st_act_reg[0]  <= s3_act_reg;
            st_ere_reg[0]  <= ere0_next;
            st_eim_reg[0]  <= eim0_next;
            st_esat_reg[0] <= esat0_next;
            st_dz_reg[0]   <= (d_reg == '0);
            st_nre_reg[0]  <= neg_re_reg;
            st_nim_reg[0]  <= neg_im_reg;
            st_sre_reg[0]  <= (mag_re_reg >> (DW - 1)) >= d_reg;
            st_sim_reg[0]  <= (mag_im_reg >> (DW - 1)) >= d_reg;
            st_rre_reg[0]  <= mag_re_reg >> (DW - 1);
            st_rim_reg[0]  <= mag_im_reg >> (DW - 1);
            st_qre_reg[0]  <= {mag_re_reg[DW-2:0], {(FB+1){1'b0}}};
            st_qim_reg[0]  <= {mag_im_reg[DW-2:0], {(FB+1){1'b0}}};
            st_d_reg[0]    <= d_reg;
            st_op_reg[0]   <= d_reg;
            st_res_reg[0]  <= '0;
            for (int j = 0; j < STEPS; j++) begin
                st_act_reg[j+1]  <= st_act_reg[j];
                st_ere_reg[j+1]  <= st_ere_reg[j];
                st_eim_reg[j+1]  <= st_eim_reg[j];
                st_esat_reg[j+1] <= st_esat_reg[j];
                st_dz_reg[j+1]   <= st_dz_reg[j];
                st_nre_reg[j+1]  <= st_nre_reg[j];
                st_nim_reg[j+1]  <= st_nim_reg[j];
                st_sre_reg[j+1]  <= st_sre_reg[j];
                st_sim_reg[j+1]  <= st_sim_reg[j];
                st_rre_reg[j+1]  <= rre_next[j];
                st_rim_reg[j+1]  <= rim_next[j];
                st_qre_reg[j+1]  <= qre_next[j];
                st_qim_reg[j+1]  <= qim_next[j];
                st_d_reg[j+1]    <= st_d_reg[j];
                st_op_reg[j+1]   <= op_next[j];
                st_res_reg[j+1]  <= res_next[j];
            end
        end
    end

    // Final rounding of quotients and root, then result selection.
    always_comb
    begin
        logic [QW:0]   qr_re, qr_im;
        logic [DW:0]   c_re, c_im, c_mag;
        logic [PW-1:0] root;
        qr_re = ({1'b0, st_qre_reg[STEPS]} + 1'b1) >> 1;
        qr_im = ({1'b0, st_qim_reg[STEPS]} + 1'b1) >> 1;
        c_re  = clamp_sm(st_nre_reg[STEPS],
                         st_sre_reg[STEPS] ? (LIM << 1) : CW'(qr_re));
        c_im  = clamp_sm(st_nim_reg[STEPS],
                         st_sim_reg[STEPS] ? (LIM << 1) : CW'(qr_im));
        root  = (st_op_reg[STEPS] > st_res_reg[STEPS]) ?
                st_res_reg[STEPS] + 1'b1 : st_res_reg[STEPS];
        c_mag = clamp_sm(1'b0, CW'(root));
        case (st_act_reg[STEPS])
            ACT_DIV: begin
                if (st_dz_reg[STEPS]) begin
                    out_re_next   = '0;
                    out_im_next   = '0;
                    out_stat_next = STAT_DIVZ;
                end else begin
                    out_re_next   = c_re[DW-1:0];
                    out_im_next   = c_im[DW-1:0];
                    out_stat_next = (c_re[DW] | c_im[DW]) ? STAT_SAT : STAT_OK;
                end
            end
            ACT_MAG: begin
                out_re_next   = c_mag[DW-1:0];
                out_im_next   = '0;
                out_stat_next = c_mag[DW] ? STAT_SAT : STAT_OK;
            end
            default: begin
                out_re_next   = st_ere_reg[STEPS];
                out_im_next   = st_eim_reg[STEPS];
                out_stat_next = st_esat_reg[STEPS] ? STAT_SAT : STAT_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_re_reg   <= out_re_next;
            out_im_reg   <= out_im_next;
            out_stat_reg <= out_stat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res_re    = out_re_reg;
    assign res_im    = out_im_reg;
    assign status    = out_stat_reg;

endmodule
`default_nettype wire

>>> sv/cau_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks on the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
module cau_checker #(
    parameter int DATA_WIDTH = 32
) (
    input wire                    clk,
    input wire                    rst_n,
    input wire                    in_ready,
    input wire                    out_valid,
    input wire                    out_ready,
    input wire [DATA_WIDTH-1:0]   res_re,
    input wire [DATA_WIDTH-1:0]   res_im,
    input wire cau_pkg::status_t  status
);
    import cau_pkg::*;

    // A result that is not taken stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(res_re) && $stable(res_im)
        && $stable(status))
        else $error("output transaction changed while stalled");

    // The pipeline takes input exactly when its output can move.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("in_ready does not follow output stall");

    // Only the three defined status codes appear.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STAT_OK || status == STAT_DIVZ || status == STAT_SAT))
        else $error("undefined status code");

    // A divide by zero yields a zero result.
    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_DIVZ |-> res_re == '0 && res_im == '0)
        else $error("divide by zero gave a nonzero result");

endmodule

bind complex_arithmetic_unit cau_checker #(
    .DATA_WIDTH(DATA_WIDTH)
) u_cau_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_re    (res_re),
    .res_im    (res_im),
    .status    (status)
);
`default_nettype wire

>>> dv/tb_complex_arithmetic_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_complex_arithmetic_unit
// Self-checking bench for the complex ALU. Directed corner operands and then
// random operations are fed through a valid/ready driver. Each result is
// compared against a fixed-point predictor under varying idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_complex_arithmetic_unit;
    import cau_pkg::*;

    localparam int DW        = 32;
    localparam int FB        = 16;
    localparam int LATENCY   = DW + FB + 5;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        act_t              op;
        logic signed [31:0] ar, ai, br, bi;
    } operands_t;

    typedef struct packed {
        logic signed [31:0] re, im;
        status_t           st;
    } result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    act_t action = ACT_ADD;
    logic signed [31:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] res_re, res_im;
    status_t status;

    operands_t pending_ops[$];
    result_t   expected_results[$];
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_off = 0;
    int        errors = 0;
    longint    cycles = 0;
    bit        stim_done = 1'b0;

    complex_arithmetic_unit #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .a_re(a_re), .a_im(a_im), .b_re(b_re), .b_im(b_im),
        .out_valid(out_valid), .out_ready(out_ready), .res_re(res_re),
        .res_im(res_im), .status(status)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Clamp a signed wide value into 32 bits, noting saturation.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Round a signed value with 2*FB fraction bits to FB bits, ties away from zero.
    function automatic logic signed [127:0] round_prod(input logic signed [127:0] v);
        logic [127:0] m;
        m = (v < 0) ? -v : v;
        m = (m + (128'd1 << (FB - 1))) >> FB;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    // round(n * 2^FB / d), ties away from zero; d positive.
    function automatic logic signed [127:0] div_round(input logic signed [127:0] n,
                                                      input logic [127:0] d);
        logic [127:0] m, q;
        m = (n < 0) ? -n : n;
        q = ((m << (FB + 1)) / d + 1) >> 1;
        return (n < 0) ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic [127:0] sqrt_round(input logic [127:0] s);
        logic [127:0] r;
        r = 0;
        for (int b = 63; b >= 0; b--)
        begin
            if ((r | (128'd1 << b)) * (r | (128'd1 << b)) <= s)
                r = r | (128'd1 << b);
        end
        if (s - r * r > r)
            r = r + 1;
        return r;
    endfunction

    function automatic result_t predict_alu(input operands_t x);
        result_t r;
        bit sat;
        logic signed [127:0] ar, ai, br, bi, d;
        sat = 1'b0;
        ar = x.ar;
        ai = x.ai;
        br = x.br;
        bi = x.bi;
        r.re = '0;
        r.im = '0;
        r.st = STAT_OK;
        case (x.op)
            ACT_ADD:
            begin
                r.re = clamp32(ar + br, sat);
                r.im = clamp32(ai + bi, sat);
            end
            ACT_SUB:
            begin
                r.re = clamp32(ar - br, sat);
                r.im = clamp32(ai - bi, sat);
            end
            ACT_MUL:
            begin
                r.re = clamp32(round_prod(ar * br - ai * bi), sat);
                r.im = clamp32(round_prod(ar * bi + ai * br), sat);
            end
            ACT_DIV:
            begin
                d = br * br + bi * bi;
                if (d == 0)
                    r.st = STAT_DIVZ;
                else
                begin
                    r.re = clamp32(div_round(ar * br + ai * bi, d), sat);
                    r.im = clamp32(div_round(ai * br - ar * bi, d), sat);
                end
            end
            ACT_CONJ:
            begin
                r.re = x.ar;
                r.im = clamp32(-ai, sat);
            end
            ACT_MAG:
                r.re = clamp32($signed(sqrt_round(ar * ar + ai * ai)), sat);
            default:
            begin
            end
        endcase
        if (sat && r.st == STAT_OK)
            r.st = STAT_SAT;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h80000000;
            1: return 32'h7fffffff;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
            4, 5: return $signed($urandom_range(0, 32'h1ffff)) - 32'sh10000;
            default: return $urandom;
        endcase
    endfunction

    task automatic push_item(input act_t op, input logic [31:0] ar, ai, br, bi);
        operands_t x;
        x.op = op;
        x.ar = ar;
        x.ai = ai;
        x.br = br;
        x.bi = bi;
        pending_ops.push_back(x);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Driver: offers queued transactions, holding payload until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (!in_valid || in_ready)
            begin
                if (pending_ops.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    operands_t x;
                    x = pending_ops.pop_front();
                    in_valid <= 1'b1;
                    action   <= x.op;
                    a_re     <= x.ar;
                    a_im     <= x.ai;
                    b_re     <= x.br;
                    b_im     <= x.bi;
                    expected_results.push_back(predict_alu(x));
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver ready control, with an optional long hold-off.
    always @(posedge clk)
    begin
        if (hold_off > 0)
        begin
            hold_off  <= hold_off - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Monitor: compares each result transaction with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
            end
            else
            begin
                result_t e;
                e = expected_results.pop_front();
                if (res_re !== e.re)
                begin
                    $error("res_re expected %h got %h", e.re, res_re);
                    errors++;
                end
                if (res_im !== e.im)
                begin
                    $error("res_im expected %h got %h", e.im, res_im);
                    errors++;
                end
                if (status !== e.st)
                begin
                    $error("status expected %0d got %0d", e.st, status);
                    errors++;
                end
            end
        end
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int lim[4];
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: every operation, extremes, zero divisor, unused codes.
        push_item(ACT_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
        push_item(ACT_ADD, 32'h00010000, 32'h00020000, 32'h00030000, 32'hfffc0000);
        push_item(ACT_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
        push_item(ACT_SUB, 32'h00050000, 32'h0, 32'h00020000, 32'h00010000);
        push_item(ACT_MUL, 32'h00020000, 32'h00030000, 32'h00040000, 32'hffff0000);
        push_item(ACT_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
        push_item(ACT_MUL, 32'h80000000, 32'h0, 32'h80000000, 32'h0);
        push_item(ACT_MUL, 32'h00000001, 32'h0, 32'h00008000, 32'h0);
        push_item(ACT_DIV, 32'h00010000, 32'h00010000, 32'h0, 32'h0);
        push_item(ACT_DIV, 32'h00060000, 32'h00020000, 32'h00010000, 32'h00010000);
        push_item(ACT_DIV, 32'h7fffffff, 32'h80000000, 32'h00000001, 32'h0);
        push_item(ACT_DIV, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
        push_item(ACT_DIV, 32'h00000001, 32'h0, 32'h00030000, 32'h0);
        push_item(ACT_CONJ, 32'h12345678, 32'h80000000, 32'h0, 32'h0);
        push_item(ACT_CONJ, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0);
        push_item(ACT_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
        push_item(ACT_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
        push_item(ACT_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
        push_item(ACT_MAG, 32'hffffffff, 32'h00000002, 32'h0, 32'h0);
        push_item(act_t'(6), 32'h11111111, 32'h2, 32'h3, 32'h4);
        push_item(act_t'(7), 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
        wait_drained();

        // Long receiver hold-off while the driver keeps offering.
        hold_off = 4 * LATENCY;
        for (int i = 0; i < 150; i++)
            push_item(act_t'($urandom_range(0, 7)), pick_value(), pick_value(),
                      pick_value(), pick_value());
        wait_drained();

        // Random phases: none, sender idle, receiver stall, both.
        lim = '{0, 77, 0, 11};
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = lim[ph];
            recv_stall_pct = (ph == 2) ? 77 : ((ph == 3) ? 11 : 0);
            for (int i = 0; i < 420; i++)
                push_item(act_t'($urandom_range(0, 15) < 14 ? $urandom_range(0, 5)
                                                             : $urandom_range(6, 7)),
                          pick_value(), pick_value(), pick_value(), pick_value());
            wait_drained();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (LATENCY + 10) @(posedge clk);

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

>>> sim.f
sv/cau_pkg.sv
sv/complex_arithmetic_unit.sv
sv/cau_checker.sv
dv/tb_complex_arithmetic_unit.sv
